### design/assert_macros.svh
// Assertion macros used by the checker file of the evaluator.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every clock edge outside of reset.
`define SAE_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Check a property on every clock edge, reset included.
`define SAE_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

### design/sae_pkg.sv
// Instruction kinds, status codes and field types of the stack evaluator.
`default_nettype none

package sae_pkg;

  typedef logic [2:0] kind_t;
  typedef logic [2:0] status_t;

  // Instruction kinds
  localparam kind_t K_RET  = 3'd0;
  localparam kind_t K_PUSH = 3'd1;
  localparam kind_t K_NEG  = 3'd2;
  localparam kind_t K_ADD  = 3'd3;
  localparam kind_t K_SUB  = 3'd4;
  localparam kind_t K_MUL  = 3'd5;
  localparam kind_t K_DIV  = 3'd6;

  // Result status codes
  localparam status_t ST_OK      = 3'd0;
  localparam status_t ST_EMPTY   = 3'd1;
  localparam status_t ST_UNDER   = 3'd2;
  localparam status_t ST_OVER    = 3'd3;
  localparam status_t ST_DIVZERO = 3'd4;

endpackage

`default_nettype wire

### design/stack_arithmetic_evaluator.sv
// Top level: stack-machine bytecode evaluator with an iterative arithmetic unit.
//
//   channel  | handshake            | payload
//   ---------+----------------------+-------------------------------------
//   cmd      | cmd_valid, cmd_stall | kind, operand, end_of_code
//   rsp      | rsp_valid, rsp_stall | result_value, status
//
// Push, negate, add, subtract and unknown kinds use execute and finish states;
// multiply adds a shift-add loop, divide abs, loop and sign steps, a sent result
// an emit state. Multiply and divide run one bit per cycle via the shared adder.
// Reset (rst, synchronous) empties the stack and drops any pending result.
// A stalled rsp holds its result; cmd is taken again once the result register
// is loaded, so a new transaction proceeds while the old result waits.
`default_nettype none

module stack_arithmetic_evaluator #(
  parameter int STACK_DEPTH = 64,
  parameter int VALUE_WIDTH = 32
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cmd_valid,
  output logic                  cmd_stall,
  input  sae_pkg::kind_t        kind,
  input  logic signed [31:0]    operand,
  input  logic                  end_of_code,
  output logic                  rsp_valid,
  input  logic                  rsp_stall,
  output logic signed [31:0]    result_value,
  output sae_pkg::status_t      status
);

  import sae_pkg::*;

  localparam int W  = VALUE_WIDTH;
  localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int DW = $clog2(STACK_DEPTH + 1);
  localparam int CW = $clog2(VALUE_WIDTH);

  // Sequencer states
  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_EXEC   = 4'd1;
  localparam logic [3:0] S_MUL    = 4'd2;
  localparam logic [3:0] S_DABS_A = 4'd3;
  localparam logic [3:0] S_DABS_B = 4'd4;
  localparam logic [3:0] S_DIV    = 4'd5;
  localparam logic [3:0] S_DSIGN  = 4'd6;
  localparam logic [3:0] S_FIN    = 4'd7;
  localparam logic [3:0] S_EMIT   = 4'd8;

  logic [3:0]    state;
  logic [DW-1:0] depth;
  logic [W-1:0]  tos;
  logic [W-1:0]  nos;
  logic [W-1:0]  acc;
  logic [W-1:0]  mcand;
  logic [W-1:0]  quot;
  logic [CW-1:0] cnt;
  logic          neg_q;
  kind_t         op_kind;
  logic [W-1:0]  op_value;
  logic          op_eoc;
  logic [31:0]   res_value;
  status_t       res_status;

  // Stack entries below the top; the top itself lives in tos
  logic [W-1:0]  mem [STACK_DEPTH];
  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  logic [AW-1:0] mem_raddr;

  logic [W:0]    alu_a;
  logic [W:0]    alu_b;
  logic          alu_sub;
  logic [W:0]    alu_sum;
  logic [W-1:0]  alu_res;
  logic          div_ge;

  logic signed [63:0] tos_ext;
  logic [31:0]        tos_word;

  assign cmd_stall = rst || (state != S_IDLE);

  assign tos_ext  = 64'($signed(tos));
  assign tos_word = tos_ext[31:0];

  // Stack memory: write the old top on push, read the entry under the top
  assign mem_we    = (state == S_EXEC) && (op_kind == K_PUSH) &&
                     (depth != '0) && (depth != DW'(STACK_DEPTH));
  assign mem_waddr = AW'(depth - DW'(1));
  assign mem_raddr = AW'(depth - DW'(2));

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= tos;
    end
    nos <= mem[mem_raddr];
  end

  // Select operands of the shared adder
  always_comb begin
    alu_a   = '0;
    alu_b   = '0;
    alu_sub = 1'b0;
    unique case (state)
      S_EXEC: begin
        if (op_kind == K_NEG) begin
          alu_b   = {1'b0, tos};
          alu_sub = 1'b1;
        end else begin
          alu_a   = {1'b0, nos};
          alu_b   = {1'b0, tos};
          alu_sub = (op_kind == K_SUB);
        end
      end
      S_MUL: begin
        alu_a = {1'b0, acc};
        alu_b = quot[0] ? {1'b0, mcand} : '0;
      end
      S_DABS_A: begin
        alu_b   = {1'b0, quot};
        alu_sub = 1'b1;
      end
      S_DABS_B: begin
        alu_b   = {1'b0, mcand};
        alu_sub = 1'b1;
      end
      S_DIV: begin
        alu_a   = {acc, quot[W-1]};
        alu_b   = {1'b0, mcand};
        alu_sub = 1'b1;
      end
      S_DSIGN: begin
        alu_b   = {1'b0, quot};
        alu_sub = neg_q;
      end
      default: ;
    endcase
  end

  sae_alu #(
    .WIDTH(W + 1)
  ) u_alu (
    .a   (alu_a),
    .b   (alu_b),
    .sub (alu_sub),
    .sum (alu_sum)
  );

  assign alu_res = alu_sum[W-1:0];
  assign div_ge  = !alu_sum[W];

  // Result valid: set when the result register loads, drop once taken
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if ((state == S_EMIT) && (!rsp_valid || !rsp_stall)) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  // Sequencer and datapath registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      depth <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (cmd_valid) begin
            op_kind  <= kind;
            op_value <= W'(operand);
            op_eoc   <= end_of_code;
            state    <= S_EXEC;
          end
        end
        S_EXEC: begin
          unique case (op_kind)
            K_RET: begin
              if (depth == '0) begin
                res_value  <= '0;
                res_status <= ST_UNDER;
              end else begin
                res_value  <= tos_word;
                res_status <= ST_OK;
              end
              depth <= '0;
              state <= S_EMIT;
            end
            K_PUSH: begin
              if (depth == DW'(STACK_DEPTH)) begin
                res_value  <= '0;
                res_status <= ST_OVER;
                depth      <= '0;
                state      <= S_EMIT;
              end else begin
                tos   <= op_value;
                depth <= depth + DW'(1);
                state <= S_FIN;
              end
            end
            K_NEG: begin
              if (depth == '0) begin
                res_value  <= '0;
                res_status <= ST_UNDER;
                state      <= S_EMIT;
              end else begin
                tos   <= alu_res;
                state <= S_FIN;
              end
            end
            K_ADD, K_SUB: begin
              if (depth < DW'(2)) begin
                res_value  <= '0;
                res_status <= ST_UNDER;
                depth      <= '0;
                state      <= S_EMIT;
              end else begin
                tos   <= alu_res;
                depth <= depth - DW'(1);
                state <= S_FIN;
              end
            end
            K_MUL: begin
              if (depth < DW'(2)) begin
                res_value  <= '0;
                res_status <= ST_UNDER;
                depth      <= '0;
                state      <= S_EMIT;
              end else begin
                acc   <= '0;
                mcand <= nos;
                quot  <= tos;
                cnt   <= CW'(VALUE_WIDTH - 1);
                state <= S_MUL;
              end
            end
            K_DIV: begin
              if (depth < DW'(2)) begin
                res_value  <= '0;
                res_status <= ST_UNDER;
                depth      <= '0;
                state      <= S_EMIT;
              end else if (tos == '0) begin
                res_value  <= '0;
                res_status <= ST_DIVZERO;
                depth      <= '0;
                state      <= S_EMIT;
              end else begin
                neg_q <= nos[W-1] ^ tos[W-1];
                quot  <= nos;
                mcand <= tos;
                state <= S_DABS_A;
              end
            end
            default: begin
              state <= S_FIN;
            end
          endcase
        end
        S_MUL: begin
          // Shift-add one multiplier bit per cycle
          acc   <= alu_res;
          mcand <= mcand << 1;
          quot  <= quot >> 1;
          if (cnt == '0) begin
            tos   <= alu_res;
            depth <= depth - DW'(1);
            state <= S_FIN;
          end else begin
            cnt <= cnt - CW'(1);
          end
        end
        S_DABS_A: begin
          if (quot[W-1]) begin
            quot <= alu_res;
          end
          state <= S_DABS_B;
        end
        S_DABS_B: begin
          if (mcand[W-1]) begin
            mcand <= alu_res;
          end
          acc   <= '0;
          cnt   <= CW'(VALUE_WIDTH - 1);
          state <= S_DIV;
        end
        S_DIV: begin
          // Restoring division, one quotient bit per cycle
          acc  <= div_ge ? alu_res : {acc[W-2:0], quot[W-1]};
          quot <= {quot[W-2:0], div_ge};
          if (cnt == '0) begin
            state <= S_DSIGN;
          end else begin
            cnt <= cnt - CW'(1);
          end
        end
        S_DSIGN: begin
          tos   <= alu_res;
          depth <= depth - DW'(1);
          state <= S_FIN;
        end
        S_FIN: begin
          if (op_eoc) begin
            if (depth == '0) begin
              res_value  <= '0;
              res_status <= ST_EMPTY;
            end else begin
              res_value  <= tos_word;
              res_status <= ST_OK;
            end
            depth <= '0;
            state <= S_EMIT;
          end else begin
            state <= S_IDLE;
          end
        end
        S_EMIT: begin
          // Load the result register once it is free
          if (!rsp_valid || !rsp_stall) begin
            result_value <= res_value;
            status       <= res_status;
            state        <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

### design/sae_alu.sv
// Shared add/subtract unit used by every arithmetic step of the evaluator.
`default_nettype none

module sae_alu #(
  parameter int WIDTH = 33
) (
  input  logic [WIDTH-1:0] a,
  input  logic [WIDTH-1:0] b,
  input  logic             sub,
  output logic [WIDTH-1:0] sum
);

  // Subtract as add of the inverted operand plus one
  assign sum = a + (b ^ {WIDTH{sub}}) + WIDTH'(sub);

endmodule

`default_nettype wire

### design/sae_checker.sv
// Port-level checker for the stack evaluator and its bind to the top level.
`default_nettype none
`include "assert_macros.svh"

module sae_checker (
  input logic             clk,
  input logic             rst,
  input logic             cmd_valid,
  input logic             cmd_stall,
  input logic             rsp_valid,
  input logic             rsp_stall,
  input logic [31:0]      result_value,
  input sae_pkg::status_t status
);

  import sae_pkg::*;

  // An error or empty result carries a zero value
  `SAE_ASSERT(a_err_zero, (rsp_valid && (status != ST_OK)) |-> (result_value == '0), "error result with nonzero value")

  // Every accepted transaction turns the sequencer busy
  `SAE_ASSERT(a_accept_busy, (cmd_valid && !cmd_stall) |=> cmd_stall, "transaction accepted without busy cycle")

  // A new result follows a busy cycle
  `SAE_ASSERT(a_rsp_after_busy, $rose(rsp_valid) |-> $past(cmd_stall), "result appeared while idle")

  // A stalled result holds
  `SAE_ASSERT(a_rsp_hold, (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(result_value) && $stable(status)), "stalled result changed")

  // Reset drops any pending result
  `SAE_ASSERT_ALWAYS(a_rst_clear, $past(rst) |-> !rsp_valid, "result valid after reset")

endmodule

bind stack_arithmetic_evaluator sae_checker u_sae_checker (
  .clk          (clk),
  .rst          (rst),
  .cmd_valid    (cmd_valid),
  .cmd_stall    (cmd_stall),
  .rsp_valid    (rsp_valid),
  .rsp_stall    (rsp_stall),
  .result_value (result_value),
  .status       (status)
);

`default_nettype wire

### tb/sv/tb_stack_arithmetic_evaluator.sv
// Testbench for the stack arithmetic evaluator: directed table, random programs, live predictor.
`timescale 1ns / 100ps

module tb_stack_arithmetic_evaluator;
  import sae_pkg::*;

  localparam int    STACK_ENTRIES = 64;
  localparam int    CLK_PERIOD    = 4;
  localparam int    QUIET_LIMIT   = 3000;
  localparam int    DRAIN_CYCLES  = 64;
  localparam int    HOLD_CYCLES   = 400;
  localparam int    PHASE_ITEMS   = 470;
  localparam int    MAX_PRINTS    = 60;
  localparam kind_t K_BAD         = 3'd7;

  typedef struct packed {
    logic [31:0] value;
    status_t     status;
  } result_t;

  typedef struct {
    kind_t       k;
    logic [31:0] op;
    logic        eoc;
    bit          typed;
    logic [31:0] exp_value;
    status_t     exp_status;
  } dir_row_t;

  logic               clk = 1'b0;
  logic               rst;
  logic               cmd_valid;
  logic               cmd_stall;
  kind_t              kind;
  logic signed [31:0] operand;
  logic               end_of_code;
  logic               rsp_valid;
  logic               rsp_stall;
  logic signed [31:0] result_value;
  status_t            status;

  // Predictor state: operand stack and its fill level
  logic [31:0] eval_stack [STACK_ENTRIES];
  int          eval_depth = 0;

  result_t  pending_results [$];
  dir_row_t dir_rows [$];
  int       err_count = 0;
  int       items_sent = 0;
  int       send_idle_pct = 0;
  int       rsp_stall_pct = 0;
  bit       hold_req = 1'b0;
  int       hold_left = 0;
  int       quiet_cycles = 0;

  stack_arithmetic_evaluator #(
    .STACK_DEPTH(STACK_ENTRIES),
    .VALUE_WIDTH(32)
  ) i_dut (
    .clk(clk),
    .rst(rst),
    .cmd_valid(cmd_valid),
    .cmd_stall(cmd_stall),
    .kind(kind),
    .operand(operand),
    .end_of_code(end_of_code),
    .rsp_valid(rsp_valid),
    .rsp_stall(rsp_stall),
    .result_value(result_value),
    .status(status)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // Print one mismatch line (up to a cap) and count it
  task automatic report_mismatch(input string what, input logic [31:0] exp_v,
                                 input logic [31:0] got_v);
    err_count++;
    if (err_count <= MAX_PRINTS)
      $display("mismatch %s: expected %h got %h at %0t", what, exp_v, got_v, $time);
  endtask

  // Append one row to the directed table
  task automatic add_row(input dir_row_t row);
    dir_rows = {dir_rows, row};
  endtask

  // Evaluate one instruction on the shadow stack; return 1 when it yields a result
  function automatic bit eval_instr(input kind_t k, input logic [31:0] op, input logic eoc,
                                    output result_t res);
    logic [31:0]        lhs;
    logic [31:0]        rhs;
    logic [31:0]        val;
    logic signed [63:0] quo;
    res.value  = '0;
    res.status = ST_OK;
    case (k)
      K_RET: begin
        if (eval_depth == 0) begin
          res.status = ST_UNDER;
          return 1'b1;
        end
        res.value  = eval_stack[eval_depth - 1];
        eval_depth = 0;
        return 1'b1;
      end
      K_PUSH: begin
        if (eval_depth >= STACK_ENTRIES) begin
          eval_depth = 0;
          res.status = ST_OVER;
          return 1'b1;
        end
        eval_stack[eval_depth] = op;
        eval_depth++;
      end
      K_NEG: begin
        if (eval_depth < 1) begin
          res.status = ST_UNDER;
          return 1'b1;
        end
        eval_stack[eval_depth - 1] = -eval_stack[eval_depth - 1];
      end
      K_ADD, K_SUB, K_MUL, K_DIV: begin
        if (eval_depth < 2) begin
          eval_depth = 0;
          res.status = ST_UNDER;
          return 1'b1;
        end
        rhs = eval_stack[eval_depth - 1];
        lhs = eval_stack[eval_depth - 2];
        case (k)
          K_ADD: val = lhs + rhs;
          K_SUB: val = lhs - rhs;
          K_MUL: val = lhs * rhs;
          default: begin
            if (rhs == '0) begin
              eval_depth = 0;
              res.status = ST_DIVZERO;
              return 1'b1;
            end
            // widen so the most negative value over -1 wraps instead of trapping
            quo = $signed({{32{lhs[31]}}, lhs}) / $signed({{32{rhs[31]}}, rhs});
            val = quo[31:0];
          end
        endcase
        eval_depth--;
        eval_stack[eval_depth - 1] = val;
      end
      default: ;
    endcase
    if (eoc) begin
      if (eval_depth == 0) begin
        res.status = ST_EMPTY;
        return 1'b1;
      end
      res.value  = eval_stack[eval_depth - 1];
      eval_depth = 0;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  // Offer one instruction after a random gap; predict once the transaction is taken
  task automatic drive_instr(input kind_t k, input logic [31:0] op, input logic eoc,
                             input bit typed, input logic [31:0] exp_v, input status_t exp_s);
    result_t res;
    bit      has_res;
    while ($urandom_range(99) < send_idle_pct) begin
      cmd_valid <= 1'b0;
      @(negedge clk);
    end
    cmd_valid   <= 1'b1;
    kind        <= k;
    operand     <= op;
    end_of_code <= eoc;
    do @(posedge clk); while (cmd_stall);
    has_res = eval_instr(k, op, eoc, res);
    if (typed) begin
      res.value  = exp_v;
      res.status = exp_s;
      has_res    = 1'b1;
    end
    if (has_res)
      pending_results = {pending_results, res};
    if (k != K_BAD || eoc)
      items_sent++;
    @(negedge clk);
  endtask

  task automatic send_instr(input kind_t k, input logic [31:0] op, input logic eoc);
    drive_instr(k, op, eoc, 1'b0, '0, ST_OK);
  endtask

  // Mix extremes, small signed values and full-range values
  function automatic logic [31:0] rand_value();
    int pick;
    pick = $urandom_range(99);
    if (pick < 30)
      return $urandom;
    if (pick < 45) begin
      case ($urandom_range(4))
        0: return 32'h7fff_ffff;
        1: return 32'h8000_0000;
        2: return 32'hffff_ffff;
        3: return 32'h0000_0000;
        default: return 32'h0000_0001;
      endcase
    end
    return $urandom_range(40) - 20;
  endfunction

  function automatic kind_t pick_binop();
    case ($urandom_range(3))
      0: return K_ADD;
      1: return K_SUB;
      2: return K_MUL;
      default: return K_DIV;
    endcase
  endfunction

  // Send one random program: mostly well-formed, some stack fills, some noise
  task automatic run_program();
    int    style;
    int    len;
    int    depth_est;
    kind_t k;
    style     = $urandom_range(99);
    depth_est = 0;
    if (style < 72) begin
      len = ($urandom_range(9) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 10);
      for (int i = 0; i < len; i++) begin
        if (depth_est < 2 && !(depth_est == 1 && $urandom_range(4) == 0)) begin
          send_instr(K_PUSH, rand_value(), 1'b0);
          depth_est++;
        end else if (depth_est == 1) begin
          send_instr(K_NEG, $urandom, 1'b0);
        end else if (depth_est < 60 && $urandom_range(3) == 0) begin
          send_instr(K_PUSH, rand_value(), 1'b0);
          depth_est++;
        end else if ($urandom_range(5) == 0) begin
          send_instr(K_NEG, $urandom, 1'b0);
        end else begin
          send_instr(pick_binop(), $urandom, 1'b0);
          depth_est--;
        end
      end
      // close with return or by marking the last instruction
      if ($urandom_range(1) == 0)
        send_instr(K_RET, $urandom, ($urandom_range(3) == 0));
      else if (depth_est >= 2)
        send_instr(pick_binop(), $urandom, 1'b1);
      else
        send_instr(K_PUSH, rand_value(), 1'b1);
    end else if (style < 82) begin
      // fill the stack to just below, at or past its depth
      len = $urandom_range(STACK_ENTRIES - 1, STACK_ENTRIES + 2);
      for (int i = 0; i < len; i++)
        send_instr(K_PUSH, rand_value(), 1'b0);
      send_instr(K_RET, $urandom, 1'b0);
    end else begin
      len = $urandom_range(1, 8);
      for (int i = 0; i < len; i++) begin
        k = kind_t'($urandom_range(7));
        send_instr(k, (k == K_PUSH) ? rand_value() : $urandom, ($urandom_range(4) == 0));
      end
    end
  endtask

  // Receiver: random stall, or a long hold when requested
  always @(negedge clk) begin
    if (hold_req) begin
      hold_req  = 1'b0;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      rsp_stall <= 1'b1;
    end else begin
      rsp_stall <= ($urandom_range(99) < rsp_stall_pct);
    end
  end

  // Check each result transaction against the oldest expectation
  always @(posedge clk) begin : check_results
    result_t exp_res;
    if (!rst && rsp_valid && !rsp_stall) begin
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected result", '0, result_value);
      end else begin
        exp_res = pending_results.pop_front();
        if (result_value !== exp_res.value)
          report_mismatch("result_value", exp_res.value, result_value);
        if (status !== exp_res.status)
          report_mismatch("status", 32'(exp_res.status), 32'(status));
      end
    end
  end

  // Watchdog: end the run after too long without any transaction
  always @(posedge clk) begin
    if (rst || (cmd_valid && !cmd_stall) || (rsp_valid && !rsp_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    rst         = 1'b1;
    cmd_valid   = 1'b0;
    kind        = K_RET;
    operand     = '0;
    end_of_code = 1'b0;
    rsp_stall   = 1'b0;

    // Directed table; typed rows carry the obvious answer, the rest use the predictor
    add_row(dir_row_t'{K_RET,  32'h0000_0000, 1'b0, 1'b1, 32'h0, ST_UNDER});
    add_row(dir_row_t'{K_PUSH, 32'h7fff_ffff, 1'b0, 1'b0, 32'h0, ST_OK});
    add_row(dir_row_t'{K_PUSH, 32'h0000_0001, 1'b0, 1'b0, 32'h0, ST_OK});
    add_row(dir_row_t'{K_ADD,  32'hffff_ffff, 1'b0, 1'b0, 32'h0, ST_OK});
    add_row(dir_row_t'{K_RET,  32'h0000_0000, 1'b0, 1'b1, 32'h8000_0000, ST_OK});
    add_row(dir_row_t'{K_PUSH, 32'h8000_0000, 1'b0, 1'b0, 32'h0, ST_OK});
    add_row(dir_row_t'{K_PUSH, 32'hffff_ffff, 1'b0, 1'b0, 32'h0, ST_OK});
    add_row(dir_row_t'{K_DIV,  32'h0000_0000, 1'b1, 1'b1, 32'h8000_0000, ST_OK});
    add_row(dir_row_t'{K_NEG,  32'h0000_0000, 1'b0, 1'b1, 32'h0, ST_UNDER});
    add_row(dir_row_t'{K_PUSH, 32'h0000_0005, 1'b0, 1'b0, 32'h0, ST_OK});
    add_row(dir_row_t'{K_ADD,  32'h0000_0000, 1'b0, 1'b1, 32'h0, ST_UNDER});
    add_row(dir_row_t'{K_PUSH, 32'h0000_0007, 1'b0, 1'b0, 32'h0, ST_OK});
    add_row(dir_row_t'{K_PUSH, 32'h0000_0000, 1'b0, 1'b0, 32'h0, ST_OK});
    add_row(dir_row_t'{K_DIV,  32'h0000_0000, 1'b1, 1'b1, 32'h0, ST_DIVZERO});
    add_row(dir_row_t'{K_BAD,  32'hffff_ffff, 1'b1, 1'b1, 32'h0, ST_EMPTY});
    add_row(dir_row_t'{K_PUSH, 32'hffff_fff9, 1'b0, 1'b0, 32'h0, ST_OK});
    add_row(dir_row_t'{K_PUSH, 32'h0000_0002, 1'b0, 1'b0, 32'h0, ST_OK});
    add_row(dir_row_t'{K_DIV,  32'h0000_0000, 1'b0, 1'b0, 32'h0, ST_OK});
    add_row(dir_row_t'{K_BAD,  32'h5555_aaaa, 1'b0, 1'b0, 32'h0, ST_OK});
    add_row(dir_row_t'{K_NEG,  32'h0000_0000, 1'b0, 1'b0, 32'h0, ST_OK});
    add_row(dir_row_t'{K_PUSH, 32'h8000_0000, 1'b0, 1'b0, 32'h0, ST_OK});
    add_row(dir_row_t'{K_MUL,  32'h0000_0000, 1'b0, 1'b0, 32'h0, ST_OK});
    add_row(dir_row_t'{K_PUSH, 32'h7fff_ffff, 1'b0, 1'b0, 32'h0, ST_OK});
    add_row(dir_row_t'{K_SUB,  32'h0000_0000, 1'b1, 1'b0, 32'h0, ST_OK});
    add_row(dir_row_t'{K_PUSH, 32'h0000_002a, 1'b0, 1'b0, 32'h0, ST_OK});
    add_row(dir_row_t'{K_RET,  32'h0000_0000, 1'b1, 1'b1, 32'h0000_002a, ST_OK});

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (dir_rows[i])
      drive_instr(dir_rows[i].k, dir_rows[i].op, dir_rows[i].eoc, dir_rows[i].typed,
                  dir_rows[i].exp_value, dir_rows[i].exp_status);

    // Random programs over four idling phases
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin send_idle_pct = 0;  rsp_stall_pct = 0;  end
        1: begin send_idle_pct = 87; rsp_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  rsp_stall_pct = 87; end
        default: begin send_idle_pct = 26; rsp_stall_pct = 26; end
      endcase
      while (items_sent < dir_rows.size() + (phase + 1) * PHASE_ITEMS) begin
        // back up the result side while items keep coming
        if (phase == 0 && items_sent >= dir_rows.size() + PHASE_ITEMS / 2 && hold_left == 0
            && !hold_req && send_idle_pct == 0 && rsp_stall_pct == 0) begin
          hold_req      = 1'b1;
          rsp_stall_pct = 1;
        end
        run_program();
      end
    end
    cmd_valid <= 1'b0;

    // Drain outstanding results, then let the pipeline settle
    while (pending_results.size() != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (err_count == 0 && pending_results.size() == 0)
      $display("TB_OK");
    else
      $display("TB_ERROR");
    $finish;
  end

endmodule
